FILE: sv/psc_pkg.sv
package psc_pkg;

    localparam int SCREEN_W_DEF     = 320;
    localparam int SCREEN_H_DEF     = 200;
    localparam int CURSOR_MAX_W_DEF = 64;
    localparam int CURSOR_MAX_H_DEF = 64;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

    typedef enum logic [2:0] {
        OP_SCREEN_PIX = 3'd0,
        OP_SCREEN_PAL = 3'd1,
        OP_CURSOR_PAL = 3'd2,
        OP_CURSOR_PIX = 3'd3,
        OP_SCANOUT    = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAKE_X       = 3'd0,
        REG_SHAKE_Y       = 3'd1,
        REG_CURSOR_LEFT   = 3'd2,
        REG_CURSOR_TOP    = 3'd3,
        REG_CURSOR_WIDTH  = 3'd4,
        REG_CURSOR_HEIGHT = 3'd5,
        REG_CURSOR_KEY    = 3'd6,
        REG_CURSOR_MODE   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic        scan;
        logic        scr_hit;
        logic        cur_hit;
        logic [7:0]  key;
        logic        cpal;
        logic        spal_we;
        logic        cpal_we;
        logic [7:0]  pal_idx;
        logic [23:0] rgb;
    } psc_ctl_t;

endpackage

FILE: sv/psc_ram.sv
module psc_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/psc_addr.sv
module psc_addr
    import psc_pkg::*;
#(
    parameter int SCREEN_W     = SCREEN_W_DEF,
    parameter int SCREEN_H     = SCREEN_H_DEF,
    parameter int CURSOR_MAX_W = CURSOR_MAX_W_DEF,
    parameter int CURSOR_MAX_H = CURSOR_MAX_H_DEF,
    parameter int SA_W = (SCREEN_W * SCREEN_H > 1) ? $clog2(SCREEN_W * SCREEN_H) : 1,
    parameter int CA_W = (CURSOR_MAX_W * CURSOR_MAX_H > 1) ?
                         $clog2(CURSOR_MAX_W * CURSOR_MAX_H) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [2:0]         operation,
    input  logic [9:0]         pos_x,
    input  logic [9:0]         pos_y,
    input  logic [7:0]         index_value,
    input  logic [23:0]        rgb_color,
    input  logic signed [9:0]  shake_x,
    input  logic signed [9:0]  shake_y,
    input  logic signed [10:0] cursor_left,
    input  logic signed [10:0] cursor_top,
    input  logic [6:0]         cursor_width,
    input  logic [6:0]         cursor_height,
    input  logic [7:0]         cursor_key,
    input  logic [1:0]         cursor_mode,
    output logic               scr_we,
    output logic [SA_W-1:0]    scr_addr,
    output logic [7:0]         scr_wdata,
    output logic               cur_we,
    output logic [CA_W-1:0]    cur_addr,
    output logic [7:0]         cur_wdata,
    output psc_ctl_t           ctl
);

    localparam logic [10:0]        SW_U  = 11'(SCREEN_W);
    localparam logic [10:0]        SH_U  = 11'(SCREEN_H);
    localparam logic signed [11:0] SW_S  = 12'(SCREEN_W);
    localparam logic signed [11:0] SH_S  = 12'(SCREEN_H);
    localparam logic [10:0]        CMW_U = 11'(CURSOR_MAX_W);
    localparam logic [10:0]        CMH_U = 11'(CURSOR_MAX_H);
    localparam logic [6:0]         CMW_7 = 7'(CURSOR_MAX_W);
    localparam logic [6:0]         CMH_7 = 7'(CURSOR_MAX_H);

    op_t               op;
    logic              in_frame;
    logic signed [11:0] sx;
    logic signed [11:0] sy;
    logic signed [11:0] dx;
    logic signed [11:0] dy;
    logic [6:0]        cw;
    logic [6:0]        ch;
    logic              scr_hit;
    logic              cur_hit;
    logic [9:0]        scol;
    logic [9:0]        srow;
    logic [5:0]        ccol;
    logic [5:0]        crow;
    logic              swr_ok;
    logic              cwr_ok;

    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic              s1_scr_we_reg;
    logic              s1_cur_we_reg;
    logic              s1_scr_hit_reg;
    logic              s1_cur_hit_reg;
    logic [9:0]        s1_scol_reg;
    logic [9:0]        s1_srow_reg;
    logic [5:0]        s1_ccol_reg;
    logic [5:0]        s1_crow_reg;
    logic [7:0]        s1_idx_reg;
    logic [23:0]       s1_rgb_reg;
    logic [7:0]        s1_key_reg;
    logic              s1_cpal_reg;

    logic [20:0]       scr_prod;
    logic [20:0]       scr_sum;
    logic [12:0]       cur_prod;
    logic [12:0]       cur_sum;
    psc_ctl_t          ctl_next;
    psc_ctl_t          ctl_reg;

    always_comb
    begin
        op       = op_t'(operation);
        in_frame = ({1'b0, pos_x} < SW_U) && ({1'b0, pos_y} < SH_U);
        sx       = $signed({2'b00, pos_x}) - $signed({{2{shake_x[9]}}, shake_x});
        sy       = $signed({2'b00, pos_y}) - $signed({{2{shake_y[9]}}, shake_y});
        dx       = $signed({2'b00, pos_x}) - $signed({cursor_left[10], cursor_left});
        dy       = $signed({2'b00, pos_y}) - $signed({cursor_top[10], cursor_top});
        cw       = (cursor_width > CMW_7) ? CMW_7 : cursor_width;
        ch       = (cursor_height > CMH_7) ? CMH_7 : cursor_height;
        scr_hit  = in_frame && (sx >= 0) && (sx < SW_S) && (sy >= 0) && (sy < SH_S);
        cur_hit  = in_frame && cursor_mode[0] && (cw != 7'd0) && (ch != 7'd0)
                   && (dx >= 0) && (dx < $signed({5'b0, cw}))
                   && (dy >= 0) && (dy < $signed({5'b0, ch}));
        swr_ok   = in_frame;
        cwr_ok   = ({1'b0, pos_x} < CMW_U) && ({1'b0, pos_y} < CMH_U);
        if (op == OP_SCREEN_PIX)
        begin
            scol = pos_x;
            srow = pos_y;
        end
        else if (scr_hit)
        begin
            scol = sx[9:0];
            srow = sy[9:0];
        end
        else
        begin
            scol = 10'd0;
            srow = 10'd0;
        end
        if (op == OP_CURSOR_PIX)
        begin
            ccol = pos_x[5:0];
            crow = pos_y[5:0];
        end
        else if (cur_hit)
        begin
            ccol = dx[5:0];
            crow = dy[5:0];
        end
        else
        begin
            ccol = 6'd0;
            crow = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg      <= op;
        s1_scr_we_reg  <= accept && (op == OP_SCREEN_PIX) && swr_ok;
        s1_cur_we_reg  <= accept && (op == OP_CURSOR_PIX) && cwr_ok;
        s1_scr_hit_reg <= scr_hit;
        s1_cur_hit_reg <= cur_hit;
        s1_scol_reg    <= scol;
        s1_srow_reg    <= srow;
        s1_ccol_reg    <= ccol;
        s1_crow_reg    <= crow;
        s1_idx_reg     <= index_value;
        s1_rgb_reg     <= rgb_color;
        s1_key_reg     <= cursor_key;
        s1_cpal_reg    <= cursor_mode[1];
    end

    always_comb
    begin
        scr_prod  = {11'b0, s1_srow_reg} * {10'b0, SW_U};
        scr_sum   = scr_prod + {11'b0, s1_scol_reg};
        cur_prod  = {7'b0, s1_crow_reg} * {6'b0, CMW_7};
        cur_sum   = cur_prod + {7'b0, s1_ccol_reg};
        scr_we    = s1_scr_we_reg;
        scr_addr  = scr_sum[SA_W-1:0];
        scr_wdata = s1_idx_reg;
        cur_we    = s1_cur_we_reg;
        cur_addr  = cur_sum[CA_W-1:0];
        cur_wdata = s1_idx_reg;

        ctl_next.scan    = s1_valid_reg && (s1_op_reg == OP_SCANOUT);
        ctl_next.scr_hit = s1_scr_hit_reg;
        ctl_next.cur_hit = s1_cur_hit_reg;
        ctl_next.key     = s1_key_reg;
        ctl_next.cpal    = s1_cpal_reg;
        ctl_next.spal_we = s1_valid_reg && (s1_op_reg == OP_SCREEN_PAL);
        ctl_next.cpal_we = s1_valid_reg && (s1_op_reg == OP_CURSOR_PAL);
        ctl_next.pal_idx = s1_idx_reg;
        ctl_next.rgb     = s1_rgb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    assign ctl = ctl_reg;

    a_store_we_excl : assert property (@(posedge clk) disable iff (!rst_n)
        !(scr_we && cur_we))
        else $error("screen and cursor store written by one transfer");

    a_we_follows_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (scr_we || cur_we) |-> $past(accept))
        else $error("store write without an accepted transfer");

    a_scan_follows_accept : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan |-> $past(accept, 2))
        else $error("scanout in flight without an accepted transfer");

endmodule

FILE: sv/psc_blend.sv
module psc_blend
    import psc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  psc_ctl_t    ctl,
    input  logic [7:0]  scr_idx,
    input  logic [7:0]  cur_idx,
    output logic        spal_we,
    output logic        cpal_we,
    output logic [7:0]  pal_waddr,
    output logic [23:0] pal_wdata,
    output logic [7:0]  pal_raddr,
    input  logic [23:0] spal_rdata,
    input  logic [23:0] cpal_rdata,
    output logic        done,
    output logic [31:0] pixel_word
);

    logic        use_cur;
    logic        s3_valid_reg;
    logic        s3_black_reg;
    logic        s3_sel_reg;
    logic        done_reg;
    logic [31:0] pixel_next;
    logic [31:0] pixel_reg;

    always_comb
    begin
        use_cur   = ctl.cur_hit && (cur_idx != ctl.key);
        spal_we   = ctl.spal_we;
        cpal_we   = ctl.cpal_we;
        pal_waddr = ctl.pal_idx;
        pal_wdata = ctl.rgb;
        pal_raddr = use_cur ? cur_idx : scr_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= ctl.scan;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_black_reg <= !ctl.scr_hit && !use_cur;
        s3_sel_reg   <= use_cur && ctl.cpal;
        pixel_reg    <= pixel_next;
    end

    always_comb
    begin
        if (s3_black_reg)
        begin
            pixel_next = {OPAQUE_ALPHA, 24'h000000};
        end
        else if (s3_sel_reg)
        begin
            pixel_next = {OPAQUE_ALPHA, cpal_rdata};
        end
        else
        begin
            pixel_next = {OPAQUE_ALPHA, spal_rdata};
        end
    end

    assign done       = done_reg;
    assign pixel_word = pixel_reg;

    a_scan_latency : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan |-> ##2 done)
        else $error("scanout transfer lost in the blend stages");

    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctl.scan, 2))
        else $error("result strobe without a scanout transfer");

    a_pal_we_excl : assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.scan && (spal_we || cpal_we)) && !(spal_we && cpal_we))
        else $error("palette write overlaps another transfer in one stage");

endmodule

FILE: sv/palette_scanout_with_cursor_overlay.sv
// Palette scanout with a hardware cursor overlay. One transfer is taken on every clock at
// which start is high; busy is never raised, so a new transfer may follow each cycle.
// Each scanout transfer yields one pixel_word with done high for one cycle, in transfer
// order; write transfers yield nothing. The result passes through the screen and cursor
// stores (address stage, then registered read) and then the palette memories (registered
// read, then output register). Every memory is touched at one fixed stage, so writes and
// reads keep transfer order without any stall. The receiver cannot hold results off.
// Stores need no clearing after reset.
module palette_scanout_with_cursor_overlay
    import psc_pkg::*;
#(
    parameter int SCREEN_W     = SCREEN_W_DEF,
    parameter int SCREEN_H     = SCREEN_H_DEF,
    parameter int CURSOR_MAX_W = CURSOR_MAX_W_DEF,
    parameter int CURSOR_MAX_H = CURSOR_MAX_H_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            operation,
    input  logic [9:0]            pos_x,
    input  logic [9:0]            pos_y,
    input  logic [7:0]            index_value,
    input  logic [23:0]           rgb_color,
    output logic                  done,
    output logic [31:0]           pixel_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SCR_DEPTH = SCREEN_W * SCREEN_H;
    localparam int CUR_DEPTH = CURSOR_MAX_W * CURSOR_MAX_H;
    localparam int SA_W = (SCR_DEPTH > 1) ? $clog2(SCR_DEPTH) : 1;
    localparam int CA_W = (CUR_DEPTH > 1) ? $clog2(CUR_DEPTH) : 1;

    logic signed [9:0]  shake_x_reg;
    logic signed [9:0]  shake_y_reg;
    logic signed [10:0] cursor_left_reg;
    logic signed [10:0] cursor_top_reg;
    logic [6:0]         cursor_width_reg;
    logic [6:0]         cursor_height_reg;
    logic [7:0]         cursor_key_reg;
    logic [1:0]         cursor_mode_reg;

    logic               accept;
    logic               scr_we;
    logic [SA_W-1:0]    scr_addr;
    logic [7:0]         scr_wdata;
    logic [7:0]         scr_rdata;
    logic               cur_we;
    logic [CA_W-1:0]    cur_addr;
    logic [7:0]         cur_wdata;
    logic [7:0]         cur_rdata;
    psc_ctl_t           ctl;
    logic               spal_we;
    logic               cpal_we;
    logic [7:0]         pal_waddr;
    logic [23:0]        pal_wdata;
    logic [7:0]         pal_raddr;
    logic [23:0]        spal_rdata;
    logic [23:0]        cpal_rdata;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shake_x_reg       <= '0;
            shake_y_reg       <= '0;
            cursor_left_reg   <= '0;
            cursor_top_reg    <= '0;
            cursor_width_reg  <= '0;
            cursor_height_reg <= '0;
            cursor_key_reg    <= '0;
            cursor_mode_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SHAKE_X:       shake_x_reg       <= cfg_data[9:0];
                REG_SHAKE_Y:       shake_y_reg       <= cfg_data[9:0];
                REG_CURSOR_LEFT:   cursor_left_reg   <= cfg_data[10:0];
                REG_CURSOR_TOP:    cursor_top_reg    <= cfg_data[10:0];
                REG_CURSOR_WIDTH:  cursor_width_reg  <= cfg_data[6:0];
                REG_CURSOR_HEIGHT: cursor_height_reg <= cfg_data[6:0];
                REG_CURSOR_KEY:    cursor_key_reg    <= cfg_data[7:0];
                REG_CURSOR_MODE:   cursor_mode_reg   <= cfg_data[1:0];
                default:           cursor_mode_reg   <= cursor_mode_reg;
            endcase
        end
    end

    psc_addr
    #(
        .SCREEN_W     (SCREEN_W),
        .SCREEN_H     (SCREEN_H),
        .CURSOR_MAX_W (CURSOR_MAX_W),
        .CURSOR_MAX_H (CURSOR_MAX_H),
        .SA_W         (SA_W),
        .CA_W         (CA_W)
    )
    u_addr
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .operation     (operation),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .index_value   (index_value),
        .rgb_color     (rgb_color),
        .shake_x       (shake_x_reg),
        .shake_y       (shake_y_reg),
        .cursor_left   (cursor_left_reg),
        .cursor_top    (cursor_top_reg),
        .cursor_width  (cursor_width_reg),
        .cursor_height (cursor_height_reg),
        .cursor_key    (cursor_key_reg),
        .cursor_mode   (cursor_mode_reg),
        .scr_we        (scr_we),
        .scr_addr      (scr_addr),
        .scr_wdata     (scr_wdata),
        .cur_we        (cur_we),
        .cur_addr      (cur_addr),
        .cur_wdata     (cur_wdata),
        .ctl           (ctl)
    );

    psc_ram #(.WIDTH(8), .DEPTH(SCR_DEPTH), .AW(SA_W)) u_screen_store
    (
        .clk   (clk),
        .we    (scr_we),
        .waddr (scr_addr),
        .wdata (scr_wdata),
        .raddr (scr_addr),
        .rdata (scr_rdata)
    );

    psc_ram #(.WIDTH(8), .DEPTH(CUR_DEPTH), .AW(CA_W)) u_cursor_store
    (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_addr),
        .wdata (cur_wdata),
        .raddr (cur_addr),
        .rdata (cur_rdata)
    );

    psc_ram #(.WIDTH(24), .DEPTH(256), .AW(8)) u_screen_palette
    (
        .clk   (clk),
        .we    (spal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .raddr (pal_raddr),
        .rdata (spal_rdata)
    );

    psc_ram #(.WIDTH(24), .DEPTH(256), .AW(8)) u_cursor_palette
    (
        .clk   (clk),
        .we    (cpal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .raddr (pal_raddr),
        .rdata (cpal_rdata)
    );

    psc_blend u_blend
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .scr_idx    (scr_rdata),
        .cur_idx    (cur_rdata),
        .spal_we    (spal_we),
        .cpal_we    (cpal_we),
        .pal_waddr  (pal_waddr),
        .pal_wdata  (pal_wdata),
        .pal_raddr  (pal_raddr),
        .spal_rdata (spal_rdata),
        .cpal_rdata (cpal_rdata),
        .done       (done),
        .pixel_word (pixel_word)
    );

endmodule
